### rtl/lobm_pkg.sv
// Shared types and constants for the limit order book matcher.
package lobm_pkg;

	localparam int BOOK_DEPTH = 32;
	localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);
	localparam int CMDQ_DEPTH = 2;
	localparam int RESQ_DEPTH = 4;

	localparam logic [1:0] MODE_MARKET = 2'd0;
	localparam logic [1:0] MODE_LIMIT  = 2'd1;

	localparam logic [1:0] KIND_TRADE  = 2'd0;
	localparam logic [1:0] KIND_RESTED = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;
	localparam logic [1:0] KIND_FULL   = 2'd3;

	typedef struct packed {
		logic        side;
		logic [1:0]  mode;
		logic [15:0] price;
		logic [15:0] quantity;
	} order_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] order_id;
		logic [31:0] resting_id;
		logic [15:0] fill_price;
		logic [15:0] amount;
		logic        last;
	} report_t;

	typedef enum logic [1:0] {
		CLS_NONE,
		CLS_MARKET,
		CLS_LIMIT,
		CLS_REST
	} cls_t;

	typedef struct packed {
		cls_t        cls;
		logic        sell;
		logic [15:0] price;
		logic [15:0] qty;
		logic [31:0] oid;
	} cmd_t;

	typedef struct packed {
		logic [15:0] px;
		logic [15:0] rem;
		logic [31:0] id;
	} entry_t;

	typedef enum logic {
		ST_IDLE,
		ST_MATCH
	} state_t;

endpackage

### rtl/lobm_front.sv
// Front end: accept orders, number and classify them, queue commands.
module lobm_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  lobm_pkg::order_t order,
	output logic            cmd_valid,
	input  logic            cmd_take,
	output lobm_pkg::cmd_t  cmd
);
	import lobm_pkg::*;

	localparam int PTR_W = $clog2(CMDQ_DEPTH);
	localparam int QC_W  = $clog2(CMDQ_DEPTH + 1);

	cmd_t             cmdq_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [QC_W-1:0]  cnt_q;
	logic [31:0]      next_number_q;
	logic             acc, take;
	cmd_t             new_cmd;

	assign full      = (cnt_q == QC_W'(CMDQ_DEPTH));
	assign acc       = push && !full;
	assign cmd_valid = (cnt_q != '0);
	assign take      = cmd_take && cmd_valid;
	assign cmd       = cmdq_q[rd_q];

	always_comb begin
		new_cmd.sell  = order.side;
		new_cmd.price = order.price;
		new_cmd.qty   = order.quantity;
		new_cmd.oid   = next_number_q;
		if (order.quantity == '0) begin
			new_cmd.cls = CLS_NONE;
		end else if (order.mode == MODE_MARKET) begin
			new_cmd.cls = CLS_MARKET;
		end else if (order.mode == MODE_LIMIT) begin
			new_cmd.cls = CLS_LIMIT;
		end else begin
			new_cmd.cls = CLS_REST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q          <= '0;
			rd_q          <= '0;
			cnt_q         <= '0;
			next_number_q <= 32'd1;
		end else begin
			if (acc) begin
				wr_q          <= (wr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
				next_number_q <= next_number_q + 32'd1;
			end
			if (take) begin
				rd_q <= (rd_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + QC_W'(acc) - QC_W'(take);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmdq_q[wr_q] <= new_cmd;
		end
	end

endmodule

### rtl/lobm_book.sv
// Back end: both sides of the book and the matching sequencer.
module lobm_book (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_take,
	input  lobm_pkg::cmd_t   cmd,
	output logic             res_valid,
	input  logic             res_ready,
	output lobm_pkg::report_t res
);
	import lobm_pkg::*;

	entry_t           bid_q [BOOK_DEPTH];
	entry_t           ask_q [BOOK_DEPTH];
	entry_t           bid_d [BOOK_DEPTH];
	entry_t           ask_d [BOOK_DEPTH];
	logic [CNT_W-1:0] bid_cnt_q, ask_cnt_q, bid_cnt_d, ask_cnt_d;
	state_t           state_q, state_d;
	cmd_t             cur_q;
	logic [15:0]      rem_q, rem_d;

	entry_t           head;
	logic [CNT_W-1:0] op_cnt, my_cnt;
	logic             px_ok, can_trade, own_full;
	logic [15:0]      fill;
	logic             do_trade, do_final;
	logic             ahead_bid [BOOK_DEPTH];
	logic             ahead_ask [BOOK_DEPTH];

	assign head     = cur_q.sell ? bid_q[0] : ask_q[0];
	assign op_cnt   = cur_q.sell ? bid_cnt_q : ask_cnt_q;
	assign my_cnt   = cur_q.sell ? ask_cnt_q : bid_cnt_q;
	assign px_ok    = (cur_q.cls == CLS_MARKET) ||
	                  (cur_q.sell ? (head.px >= cur_q.price) : (head.px <= cur_q.price));
	assign can_trade = ((cur_q.cls == CLS_MARKET) || (cur_q.cls == CLS_LIMIT)) &&
	                   (rem_q != '0) && (op_cnt != '0) && px_ok;
	assign fill     = (head.rem < rem_q) ? head.rem : rem_q;
	assign own_full = (my_cnt == CNT_W'(BOOK_DEPTH));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: begin
				if (res_ready && !can_trade) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_take = 1'b0;
		do_trade = 1'b0;
		do_final = 1'b0;
		unique case (state_q)
			ST_IDLE:  cmd_take = cmd_valid;
			ST_MATCH: begin
				do_trade = res_ready && can_trade;
				do_final = res_ready && !can_trade;
			end
			default: ;
		endcase
	end

	always_comb begin
		res_valid      = do_trade || do_final;
		res.order_id   = cur_q.oid;
		res.resting_id = '0;
		res.fill_price = '0;
		res.amount     = rem_q;
		res.last       = 1'b1;
		if (can_trade) begin
			res.kind       = KIND_TRADE;
			res.resting_id = head.id;
			res.fill_price = head.px;
			res.amount     = fill;
			res.last       = 1'b0;
		end else if (cur_q.cls == CLS_NONE || cur_q.cls == CLS_MARKET || rem_q == '0) begin
			res.kind = KIND_DONE;
		end else if (own_full) begin
			res.kind = KIND_FULL;
		end else begin
			res.kind = KIND_RESTED;
		end
	end

	always_comb begin
		for (int i = 0; i < BOOK_DEPTH; i++) begin
			ahead_bid[i] = (CNT_W'(i) < bid_cnt_q) && (bid_q[i].px >= cur_q.price);
			ahead_ask[i] = (CNT_W'(i) < ask_cnt_q) && (ask_q[i].px <= cur_q.price);
		end
	end

	always_comb begin
		entry_t nu;
		logic   ins_bid, ins_ask, pop_bid, pop_ask;
		nu.px     = cur_q.price;
		nu.rem    = rem_q;
		nu.id     = cur_q.oid;
		bid_d     = bid_q;
		ask_d     = ask_q;
		bid_cnt_d = bid_cnt_q;
		ask_cnt_d = ask_cnt_q;
		rem_d     = rem_q;
		ins_bid   = do_final && (res.kind == KIND_RESTED) && !cur_q.sell;
		ins_ask   = do_final && (res.kind == KIND_RESTED) && cur_q.sell;
		pop_bid   = do_trade && cur_q.sell && (head.rem == fill);
		pop_ask   = do_trade && !cur_q.sell && (head.rem == fill);
		if (do_trade) begin
			rem_d = rem_q - fill;
			if (cur_q.sell) begin
				bid_d[0].rem = head.rem - fill;
			end else begin
				ask_d[0].rem = head.rem - fill;
			end
		end
		if (pop_bid) begin
			for (int i = 0; i < BOOK_DEPTH - 1; i++) begin
				bid_d[i] = bid_q[i + 1];
			end
			bid_cnt_d = bid_cnt_q - 1'b1;
		end
		if (pop_ask) begin
			for (int i = 0; i < BOOK_DEPTH - 1; i++) begin
				ask_d[i] = ask_q[i + 1];
			end
			ask_cnt_d = ask_cnt_q - 1'b1;
		end
		if (ins_bid) begin
			for (int i = 0; i < BOOK_DEPTH; i++) begin
				if (!ahead_bid[i]) begin
					if (i == 0) begin
						bid_d[i] = nu;
					end else if (ahead_bid[i - 1]) begin
						bid_d[i] = nu;
					end else begin
						bid_d[i] = bid_q[i - 1];
					end
				end
			end
			bid_cnt_d = bid_cnt_q + 1'b1;
		end
		if (ins_ask) begin
			for (int i = 0; i < BOOK_DEPTH; i++) begin
				if (!ahead_ask[i]) begin
					if (i == 0) begin
						ask_d[i] = nu;
					end else if (ahead_ask[i - 1]) begin
						ask_d[i] = nu;
					end else begin
						ask_d[i] = ask_q[i - 1];
					end
				end
			end
			ask_cnt_d = ask_cnt_q + 1'b1;
		end
		if (cmd_take) begin
			rem_d = cmd.qty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bid_cnt_q <= '0;
			ask_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			bid_cnt_q <= bid_cnt_d;
			ask_cnt_q <= ask_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		bid_q <= bid_d;
		ask_q <= ask_d;
		rem_q <= rem_d;
		if (cmd_take) begin
			cur_q <= cmd;
		end
	end

endmodule

### rtl/lobm_resq.sv
// Result queue between the matching sequencer and the result port.
module lobm_resq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  lobm_pkg::report_t wr_data,
	output logic              empty,
	input  logic              pop,
	output lobm_pkg::report_t report
);
	import lobm_pkg::*;

	localparam int PTR_W = $clog2(RESQ_DEPTH);
	localparam int QC_W  = $clog2(RESQ_DEPTH + 1);

	report_t          mem_q [RESQ_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [QC_W-1:0]  cnt_q;
	logic             wr, rd;

	assign wr_ready = (cnt_q != QC_W'(RESQ_DEPTH));
	assign empty    = (cnt_q == '0);
	assign wr       = wr_valid && wr_ready;
	assign rd       = pop && !empty;
	assign report   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wr_q <= (wr_q == PTR_W'(RESQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (rd) begin
				rd_q <= (rd_q == PTR_W'(RESQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + QC_W'(wr) - QC_W'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_q] <= wr_data;
		end
	end

endmodule

### rtl/limit_order_book_matcher.sv
// Top level of the limit order book matcher.
//
//   channel  | direction | handshake                 | payload
//   orders   | in        | push / full               | order  (order_t)
//   reports  | out       | empty / pop               | report (report_t)
//
// An order is loaded into the sequencer, which then writes one report per fill
// and then one for its status; the single matching sequencer takes no new order
// until that status is written. Reset clears both book counts and sets the next
// order number to one. A full result queue holds the sequencer; up to two orders
// wait in the command queue, after which full stays high.
module limit_order_book_matcher (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  lobm_pkg::order_t  order,
	output logic              empty,
	input  logic              pop,
	output lobm_pkg::report_t report
);
	import lobm_pkg::*;

	cmd_t    cmd;
	logic    cmd_valid, cmd_take;
	report_t res;
	logic    res_valid, res_ready;

	lobm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.order     (order),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd)
	);

	lobm_book u_book (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	lobm_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (res_valid),
		.wr_ready (res_ready),
		.wr_data  (res),
		.empty    (empty),
		.pop      (pop),
		.report   (report)
	);

endmodule

### rtl/lobm_chk.sv
// Port-level checks for the limit order book matcher, bound to the top level.
module lobm_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              empty,
	input logic              pop,
	input lobm_pkg::report_t report
);
	import lobm_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("report withdrawn before pop");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(report))
		else $error("report changed while waiting");

	a_trade_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && report.kind == KIND_TRADE |-> !report.last)
		else $error("trade marked as final status");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && report.kind != KIND_TRADE |-> report.last &&
		report.resting_id == '0 && report.fill_price == '0)
		else $error("malformed status report");

endmodule

bind limit_order_book_matcher lobm_chk u_chk (.*);
